@@ rtl/assert_macros.svh @@
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCPA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SCPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/scpa_pkg.sv @@
`default_nettype none
package scpa_pkg;
  localparam int POOL_PAGES  = 4096;
  localparam int MAX_REQUEST = 64;
  localparam int NUM_CLASSES = 128;
  localparam int CHUNK_BITS  = 16;
  localparam int PAGE_W      = 12;
  localparam int LINK_W      = 13;
  localparam int REQ_W       = 7;
  localparam int CHUNK_W     = 3;
  localparam int CIDX_W      = 4;
  localparam logic [LINK_W-1:0] NULL_LINK = 13'd4096;
  localparam logic [LINK_W-1:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic load;
    logic scan_adv;
    logic take_cls;
    logic pop_take;
    logic head_wb;
    logic pool_take;
    logic push_wr;
    logic fail;
    logic head_sel_push;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic hit;
    logic last;
    logic head_null;
    logic split;
    logic pool_ok;
    logic push_ok;
  } status_t;
endpackage
`default_nettype wire

@@ rtl/scpa_dp.sv @@
`default_nettype none
module scpa_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire scpa_pkg::cmd_t                   cmd,
  output scpa_pkg::status_t                     status,
  input  wire logic [scpa_pkg::REQ_W-1:0]       request_pages,
  input  wire logic                             pool_limit_we,
  input  wire logic [scpa_pkg::LINK_W-1:0]      pool_limit,
  output logic                                  done,
  output logic                                  granted,
  output logic [scpa_pkg::PAGE_W-1:0]           first_page
);
  logic [scpa_pkg::LINK_W-1:0] head_mem [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::LINK_W-1:0] next_mem [scpa_pkg::POOL_PAGES];

  logic [scpa_pkg::NUM_CLASSES-1:0] exists;
  logic [scpa_pkg::REQ_W-1:0]       want;
  logic [scpa_pkg::CHUNK_W-1:0]     chunk;
  logic [scpa_pkg::REQ_W-1:0]       cls;
  logic [scpa_pkg::LINK_W-1:0]      page;
  logic [scpa_pkg::LINK_W-1:0]      push_page;
  logic [scpa_pkg::REQ_W-1:0]       push_size;
  logic [scpa_pkg::LINK_W-1:0]      head_q;
  logic [scpa_pkg::LINK_W-1:0]      link_q;
  logic [scpa_pkg::LINK_W-1:0]      pool_used;
  logic [scpa_pkg::LINK_W-1:0]      limit_r;

  logic [scpa_pkg::CHUNK_BITS-1:0]  chunk_bits;
  logic [scpa_pkg::CHUNK_BITS-1:0]  masked;
  logic [scpa_pkg::CIDX_W-1:0]      idx;
  logic [scpa_pkg::LINK_W-1:0]      limit_eff;
  logic [scpa_pkg::LINK_W:0]        pool_end;
  logic [scpa_pkg::REQ_W:0]         take;
  logic [scpa_pkg::REQ_W-1:0]       head_raddr;
  logic [scpa_pkg::REQ_W-1:0]       head_waddr;
  logic [scpa_pkg::LINK_W-1:0]      head_wdata;

  always_comb begin
    chunk_bits = exists[chunk*scpa_pkg::CHUNK_BITS +: scpa_pkg::CHUNK_BITS];
    masked = chunk_bits;
    if (chunk == want[scpa_pkg::REQ_W-1:scpa_pkg::CIDX_W]) begin
      masked = chunk_bits & ({scpa_pkg::CHUNK_BITS{1'b1}} << want[scpa_pkg::CIDX_W-1:0]);
    end
    idx = '0;
    for (int i = scpa_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        idx = scpa_pkg::CIDX_W'(i);
      end
    end
  end

  assign limit_eff = (limit_r > scpa_pkg::LINK_W'(scpa_pkg::POOL_PAGES)) ?
                     scpa_pkg::LINK_W'(scpa_pkg::POOL_PAGES) : limit_r;
  assign take      = {want, 1'b0};
  assign pool_end  = {1'b0, pool_used} + {{(scpa_pkg::LINK_W-scpa_pkg::REQ_W){1'b0}}, take};

  assign status.bad       = (want == '0) || (want > scpa_pkg::REQ_W'(scpa_pkg::MAX_REQUEST));
  assign status.hit       = |masked;
  assign status.last      = &chunk;
  assign status.head_null = head_q[scpa_pkg::LINK_W-1];
  assign status.split     = cls > want;
  assign status.pool_ok   = pool_end <= {1'b0, limit_eff};
  assign status.push_ok   = (push_size != '0) && !push_page[scpa_pkg::LINK_W-1];

  assign head_raddr = cmd.head_sel_push ? push_size : cls;
  assign head_waddr = cmd.head_wb ? cls : push_size;
  assign head_wdata = cmd.head_wb ? link_q : push_page;

  always_ff @(posedge clk) begin
    head_q <= head_mem[head_raddr];
    if (cmd.head_wb || cmd.push_wr) begin
      head_mem[head_waddr] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= next_mem[page[scpa_pkg::PAGE_W-1:0]];
    if (cmd.push_wr) begin
      next_mem[push_page[scpa_pkg::PAGE_W-1:0]] <= exists[push_size] ? head_q
                                                   : scpa_pkg::NULL_LINK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      want  <= request_pages;
      chunk <= request_pages[scpa_pkg::REQ_W-1:scpa_pkg::CIDX_W];
    end else if (cmd.scan_adv) begin
      chunk <= chunk + 1'b1;
    end
    if (cmd.take_cls) begin
      cls <= {chunk, idx};
    end
    if (cmd.pop_take) begin
      page <= head_q;
    end
    if (cmd.head_wb) begin
      push_page <= page + scpa_pkg::LINK_W'(want);
      push_size <= cls - want;
    end else if (cmd.pool_take) begin
      push_page <= pool_used + scpa_pkg::LINK_W'(want);
      push_size <= want;
    end
    if (cmd.head_wb) begin
      first_page <= page[scpa_pkg::PAGE_W-1:0];
    end else if (cmd.pool_take) begin
      first_page <= pool_used[scpa_pkg::PAGE_W-1:0];
    end else begin
      first_page <= '0;
    end
    granted <= cmd.head_wb || cmd.pool_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exists    <= '0;
      pool_used <= '0;
      limit_r   <= scpa_pkg::LIMIT_RESET;
      done      <= 1'b0;
    end else begin
      done <= cmd.head_wb || cmd.pool_take || cmd.fail;
      if (pool_limit_we) begin
        limit_r <= pool_limit;
      end
      if (cmd.pool_take) begin
        pool_used <= pool_end[scpa_pkg::LINK_W-1:0];
      end
      if (cmd.push_wr) begin
        exists[push_size] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/scpa_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"
module scpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire scpa_pkg::status_t status,
  output scpa_pkg::cmd_t         cmd
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_HREAD  = 9'b000000100,
    S_HCHK   = 9'b000001000,
    S_LREAD  = 9'b000010000,
    S_LWB    = 9'b000100000,
    S_POOL   = 9'b001000000,
    S_PREAD  = 9'b010000000,
    S_PWR    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.bad) begin
          cmd.fail = 1'b1;
          state_next = S_IDLE;
        end else if (status.hit) begin
          cmd.take_cls = 1'b1;
          state_next = S_HREAD;
        end else if (status.last) begin
          state_next = S_POOL;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_HREAD: state_next = S_HCHK;
      S_HCHK: begin
        if (status.head_null) begin
          state_next = S_POOL;
        end else begin
          cmd.pop_take = 1'b1;
          state_next = S_LREAD;
        end
      end
      S_LREAD: state_next = S_LWB;
      S_LWB: begin
        cmd.head_wb = 1'b1;
        state_next = status.split ? S_PREAD : S_IDLE;
      end
      S_POOL: begin
        if (status.pool_ok) begin
          cmd.pool_take = 1'b1;
          state_next = S_PREAD;
        end else begin
          cmd.fail = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PREAD: begin
        cmd.head_sel_push = 1'b1;
        state_next = status.push_ok ? S_PWR : S_IDLE;
      end
      S_PWR: begin
        cmd.push_wr = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SCPA_ASSERT_NEXT(a_one_result, clk, rst,
    cmd.head_wb || cmd.pool_take || cmd.fail,
    !(cmd.head_wb || cmd.pool_take || cmd.fail))
  `SCPA_ASSERT_NEXT(a_start_search, clk, rst, start && !busy, state == S_SEARCH)
  `SCPA_ASSERT_NEXT(a_push_ends, clk, rst, cmd.push_wr, !busy)
  `SCPA_ASSERT_NOW(a_pop_valid, clk, rst, cmd.pop_take, !status.head_null)
endmodule
`default_nettype wire

@@ rtl/size_class_page_allocator.sv @@
// channel   | ports                                   | handshake
// request   | start, busy, request_pages              | start && !busy
// result    | done, granted, first_page               | done, one cycle
// config    | pool_limit_we, pool_limit               | pool_limit_we
//
// A request is loaded while idle, then takes one to eight class search steps
// of 16 classes each, then reads the head and link memories or takes pages
// from the pool, and pushes any surplus run; busy is high after the load.
// Reset (rst, synchronous) clears classes, pool usage and sets limit to 4096.
// The receiver cannot stall; the result is shown for one cycle.
`default_nettype none
module size_class_page_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [scpa_pkg::REQ_W-1:0]  request_pages,
  input  wire logic                        pool_limit_we,
  input  wire logic [scpa_pkg::LINK_W-1:0] pool_limit,
  output logic                             done,
  output logic                             granted,
  output logic [scpa_pkg::PAGE_W-1:0]      first_page
);
  scpa_pkg::cmd_t    cmd;
  scpa_pkg::status_t status;

  scpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  scpa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .request_pages (request_pages),
    .pool_limit_we (pool_limit_we),
    .pool_limit    (pool_limit),
    .done          (done),
    .granted       (granted),
    .first_page    (first_page)
  );
endmodule
`default_nettype wire

@@ bench/size_class_page_allocator_test.sv @@
`default_nettype none
module size_class_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic                        granted;
    logic [scpa_pkg::PAGE_W-1:0] first_page;
  } grant_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [scpa_pkg::REQ_W-1:0]  request_pages = '0;
  logic                        pool_limit_we = 1'b0;
  logic [scpa_pkg::LINK_W-1:0] pool_limit = '0;
  logic                        done;
  logic                        granted;
  logic [scpa_pkg::PAGE_W-1:0] first_page;

  size_class_page_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request_pages(request_pages), .pool_limit_we(pool_limit_we),
    .pool_limit(pool_limit), .done(done), .granted(granted),
    .first_page(first_page)
  );

  // allocator shadow state
  logic                        class_live [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::LINK_W-1:0] class_top [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::LINK_W-1:0] run_link [scpa_pkg::POOL_PAGES];
  logic [scpa_pkg::LINK_W-1:0] pages_used;
  logic [scpa_pkg::LINK_W-1:0] limit_shadow;

  grant_t pending_grants[$];
  int     failures = 0;
  int     cycles = 0;
  int     burst_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic push_free_run(int page, int pages);
    if (pages == 0 || pages >= scpa_pkg::NUM_CLASSES || page >= scpa_pkg::POOL_PAGES) return;
    run_link[page] = class_live[pages] ? class_top[pages] : scpa_pkg::NULL_LINK;
    class_live[pages] = 1'b1;
    class_top[pages] = scpa_pkg::LINK_W'(page);
  endtask

  task automatic allocate_pages(input int want, output grant_t g);
    int cls;
    int page;
    int cap;
    int take;
    cls = scpa_pkg::NUM_CLASSES;
    g.granted = 1'b0;
    g.first_page = '0;
    if (want == 0 || want > scpa_pkg::MAX_REQUEST) return;
    for (int s = want; s < scpa_pkg::NUM_CLASSES; s++) begin
      if (class_live[s]) begin
        cls = s;
        break;
      end
    end
    if (cls < scpa_pkg::NUM_CLASSES && class_top[cls] < scpa_pkg::POOL_PAGES) begin
      page = class_top[cls];
      class_top[cls] = run_link[page];
      run_link[page] = scpa_pkg::NULL_LINK;
      if (cls > want) push_free_run(page + want, cls - want);
      g.granted = 1'b1;
      g.first_page = scpa_pkg::PAGE_W'(page);
      return;
    end
    cap = (limit_shadow > scpa_pkg::POOL_PAGES) ? scpa_pkg::POOL_PAGES : limit_shadow;
    take = want * 2;
    if (pages_used > cap || take > cap - pages_used) return;
    page = pages_used;
    pages_used = pages_used + scpa_pkg::LINK_W'(take);
    push_free_run(page + want, take - want);
    g.granted = 1'b1;
    g.first_page = scpa_pkg::PAGE_W'(page);
  endtask

  always @(posedge clk) begin
    grant_t exp_g;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("size_class_page_allocator regression: fail");
      $finish;
    end
    if (!rst && done) begin
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected transaction: granted %0b first_page %0d",
                 $time, granted, first_page);
        failures++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (granted !== exp_g.granted) begin
          $display("%0t granted: expected %0b actual %0b", $time, exp_g.granted, granted);
          failures++;
        end
        if (first_page !== exp_g.first_page) begin
          $display("%0t first_page: expected %0d actual %0d",
                   $time, exp_g.first_page, first_page);
          failures++;
        end
      end
    end
  end

  task automatic send_request(int pages);
    grant_t g;
    start <= 1'b1;
    request_pages <= scpa_pkg::REQ_W'(pages);
    do @(posedge clk); while (busy);
    allocate_pages(pages, g);
    pending_grants.push_back(g);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    drain();
    pool_limit <= scpa_pkg::LINK_W'(value);
    pool_limit_we <= 1'b1;
    @(posedge clk);
    pool_limit_we <= 1'b0;
    limit_shadow = scpa_pkg::LINK_W'(value);
    @(posedge clk);
  endtask

  task automatic test_invalid_sizes;
    send_request(0);
    send_request(65);
    send_request(127);
    send_request(64);
  endtask

  task automatic test_reuse_and_split;
    send_request(1);
    send_request(1);
    send_request(3);
    send_request(2);
    send_request(5);
    send_request(5);
    send_request(4);
    send_request(3);
    send_request(1);
    send_request(64);
    send_request(30);
  endtask

  task automatic test_exhausted_pool;
    write_limit(0);
    send_request(1);
    send_request(64);
    write_limit(1);
    send_request(1);
    send_request(2);
    write_limit(8191);
    send_request(7);
    send_request(50);
  endtask

  task automatic test_random(int count);
    int r;
    int pages;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 60) pages = $urandom_range(1, 8);
      else if (r < 85) pages = $urandom_range(9, 32);
      else if (r < 95) pages = $urandom_range(33, 64);
      else pages = (r & 1) ? 0 : $urandom_range(65, 127);
      send_request(pages);
    end
  endtask

  initial begin
    pages_used = '0;
    limit_shadow = scpa_pkg::LIMIT_RESET;
    for (int i = 0; i < scpa_pkg::NUM_CLASSES; i++) begin
      class_live[i] = 1'b0;
      class_top[i] = scpa_pkg::NULL_LINK;
    end
    for (int i = 0; i < scpa_pkg::POOL_PAGES; i++) run_link[i] = scpa_pkg::NULL_LINK;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_invalid_sizes();
    test_reuse_and_split();
    test_exhausted_pool();
    write_limit(1500);
    test_random(300);
    write_limit(4096);
    test_random(350);
    write_limit(2);
    test_random(150);
    write_limit(8191);
    test_random(125);
    drain();
    if (failures == 0) begin
      $display("size_class_page_allocator regression: pass");
    end else begin
      $display("size_class_page_allocator regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
